// ===== rtl/cpkf_pkg.sv =====
// Shared constants, register codes and bus types for the contact probability fusion block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cpkf_pkg;

	localparam int LEG_COUNT = 4;
	localparam int PROB_FRACTION_BITS = 15;
	localparam int PROB_W = PROB_FRACTION_BITS + 1;
	localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {PROB_FRACTION_BITS{1'b0}}};

	// Configuration port.
	localparam int REG_W = 32;
	localparam int REG_IDX_W = 2;
	localparam int ADDR_W = REG_IDX_W + 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PROCESS_NOISE = 2'd0,
		REG_HEIGHT_NOISE  = 2'd1,
		REG_FORCE_NOISE   = 2'd2
	} reg_idx_t;

	localparam logic [REG_W-1:0] PROCESS_NOISE_RST = 32'd98304;
	localparam logic [REG_W-1:0] HEIGHT_NOISE_RST  = 32'd655360;
	localparam logic [REG_W-1:0] FORCE_NOISE_RST   = 32'd1311;

	// Cycles from a register write until the denominator is valid again.
	localparam int SETTLE_W = 2;
	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

	// Datapath widths.
	localparam int DIFF_W = PROB_W + 1;
	localparam int PROD_W = REG_W + 1 + DIFF_W;
	localparam int NUM_W = PROD_W + 1;
	localparam int MAG_W = NUM_W - 1;
	localparam int MAG_LO_W = MAG_W / 2;
	localparam int MAG_HI_W = MAG_W - MAG_LO_W;
	localparam int PP_W = REG_W + MAG_HI_W;
	localparam int TOP_W = REG_W + MAG_W;
	localparam int DEN_W = 2 * REG_W + 2;
	localparam int D2_W = DEN_W + 1;
	// The correction saturates at 2^QUO_W, which already lies beyond any prior value.
	localparam int QUO_W = PROB_W + 1;
	localparam int REM_W = D2_W + QUO_W;
	localparam int DELTA_W = QUO_W + 1;
	localparam int RES_W = QUO_W + 2;

	// Stages before the divider, divider steps, and the output stage.
	localparam int PRE_STAGES = 7;
	localparam int NUM_STAGES = PRE_STAGES + QUO_W + 1;

	typedef struct packed {
		logic [REG_W-1:0] process_noise;
		logic [REG_W-1:0] height_noise;
		logic [REG_W-1:0] force_noise;
		logic [D2_W-1:0]  den2;
		logic             den_zero;
	} cfg_bus_t;

	typedef struct packed {
		logic advance;
		logic skid_load;
		logic skid_sel;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/cpkf_cfg.sv =====
// Noise registers behind the APB port, and the shared Kalman denominator built from them.
// Depends on cpkf_pkg.
`default_nettype none

module cpkf_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cpkf_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [cpkf_pkg::REG_W-1:0]   pwdata,
	output logic [cpkf_pkg::REG_W-1:0]        prdata,
	output logic                              pready,
	output cpkf_pkg::cfg_bus_t                cfg,
	output logic                              settled
);
	import cpkf_pkg::*;

	logic                   wr;
	reg_idx_t               idx;
	logic [REG_W-1:0]       q_q;
	logic [REG_W-1:0]       r1_q;
	logic [REG_W-1:0]       r2_q;
	logic [SETTLE_W-1:0]    settle_q;
	logic [REG_W:0]         sum_q;
	logic [2*REG_W-1:0]     p2_q;
	logic [2*REG_W:0]       p1_q;
	logic [DEN_W-1:0]       den_q;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= PROCESS_NOISE_RST;
			r1_q <= HEIGHT_NOISE_RST;
			r2_q <= FORCE_NOISE_RST;
		end else if (wr) begin
			case (idx)
				REG_PROCESS_NOISE: q_q <= pwdata;
				REG_HEIGHT_NOISE:  r1_q <= pwdata;
				REG_FORCE_NOISE:   r2_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PROCESS_NOISE: prdata = q_q;
			REG_HEIGHT_NOISE:  prdata = r1_q;
			REG_FORCE_NOISE:   prdata = r2_q;
			default:           prdata = '0;
		endcase
	end

	// The denominator q*(r1+r2) + r1*r2 is rebuilt through sum_q and p2_q, then p1_q, then den_q after every write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (wr) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= (REG_W+1)'(r1_q) + (REG_W+1)'(r2_q);
		p2_q <= (2*REG_W)'(r1_q) * (2*REG_W)'(r2_q);
		p1_q <= (2*REG_W+1)'(q_q) * (2*REG_W+1)'(sum_q);
		den_q <= DEN_W'(p1_q) + DEN_W'(p2_q);
	end

	assign settled = (settle_q == '0);

	assign cfg.process_noise = q_q;
	assign cfg.height_noise = r1_q;
	assign cfg.force_noise = r2_q;
	assign cfg.den2 = {den_q, 1'b0};
	assign cfg.den_zero = (den_q == '0);

	a_den_holds: assert property (@(posedge clk) disable iff (!arst_n)
		settled && !wr |=> $stable(den_q))
		else $error("denominator changed while the block was settled");

endmodule

`default_nettype wire

// ===== rtl/cpkf_ctrl.sv =====
// Valid bits of the fusion pipeline and the one-entry output skid stage.
// Depends on cpkf_pkg.
`default_nettype none

module cpkf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire logic             settled,
	output cpkf_pkg::pipe_ctl_t   ctl
);
	import cpkf_pkg::*;

	logic [NUM_STAGES:1] valid_s;
	logic                skid_valid_q;
	logic                advance;
	logic                in_fire;
	logic                out_fire;

	// The pipeline moves as a whole; it freezes only while the skid stage holds a result.
	assign advance = !skid_valid_q;
	assign in_ready = advance && settled;
	assign in_fire = in_valid && in_ready;
	assign out_valid = skid_valid_q || valid_s[NUM_STAGES];
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
			skid_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s <= {valid_s[NUM_STAGES-1:1], in_fire};
			end
			if (skid_valid_q) begin
				if (out_ready) begin
					skid_valid_q <= 1'b0;
				end
			end else if (valid_s[NUM_STAGES] && !out_ready) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	assign ctl.advance = advance;
	assign ctl.skid_load = !skid_valid_q && valid_s[NUM_STAGES] && !out_ready;
	assign ctl.skid_sel = skid_valid_q;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s[1])
		else $error("accepted request did not enter the first stage");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_s) + int'(skid_valid_q) ==
		$past($countones(valid_s) + int'(skid_valid_q)) + int'($past(in_fire))
		- int'($past(out_fire)))
		else $error("request lost or duplicated inside the pipeline");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_ready |=> $stable(valid_s))
		else $error("pipeline moved while the skid stage was full");

endmodule

`default_nettype wire

// ===== rtl/cpkf_leg.sv =====
// Datapath of one leg: innovation products, scaling by q, a pipelined restoring divider
// and the saturating correction. Control comes from cpkf_ctrl; depends on cpkf_pkg.
`default_nettype none

module cpkf_leg (
	input  wire logic                        clk,
	input  wire cpkf_pkg::cfg_bus_t          cfg,
	input  wire cpkf_pkg::pipe_ctl_t         ctl,
	input  wire logic [cpkf_pkg::PROB_W-1:0] gait_prob,
	input  wire logic [cpkf_pkg::PROB_W-1:0] height_prob,
	input  wire logic [cpkf_pkg::PROB_W-1:0] force_prob,
	output logic [cpkf_pkg::PROB_W-1:0]      fused_prob
);
	import cpkf_pkg::*;

	logic signed [DIFF_W-1:0] dh;
	logic signed [DIFF_W-1:0] df;

	logic signed [PROD_W-1:0] prod_h_s1;
	logic signed [PROD_W-1:0] prod_f_s1;
	logic [PROB_W-1:0]        g_s1;
	logic signed [NUM_W-1:0]  num_s2;
	logic [PROB_W-1:0]        g_s2;
	logic [MAG_W-1:0]         mag_s3;
	logic                     neg_s3;
	logic                     skip_s3;
	logic [PROB_W-1:0]        g_s3;
	logic [PP_W-1:0]          pp_lo_s4;
	logic [PP_W-1:0]          pp_hi_s4;
	logic                     neg_s4;
	logic                     skip_s4;
	logic [PROB_W-1:0]        g_s4;
	logic [TOP_W-1:0]         top_s5;
	logic                     neg_s5;
	logic                     skip_s5;
	logic [PROB_W-1:0]        g_s5;
	logic [REM_W-1:0]         n_s6;
	logic                     neg_s6;
	logic                     skip_s6;
	logic [PROB_W-1:0]        g_s6;

	// Divider stages; index 0 is the seventh stage, index j the seventh plus j.
	logic [REM_W-1:0]  dv_rem_s  [0:QUO_W];
	logic [QUO_W-1:0]  dv_quo_s  [0:QUO_W];
	logic              dv_ovf_s  [0:QUO_W];
	logic              dv_neg_s  [0:QUO_W];
	logic              dv_skip_s [0:QUO_W];
	logic [PROB_W-1:0] dv_g_s    [0:QUO_W];

	logic [DELTA_W-1:0]      delta;
	logic signed [RES_W-1:0] res;
	logic [PROB_W-1:0]       sat;
	logic [PROB_W-1:0]       fused_s25;
	logic [PROB_W-1:0]       skid_q;

	assign dh = $signed(DIFF_W'(height_prob) - DIFF_W'(gait_prob));
	assign df = $signed(DIFF_W'(force_prob) - DIFF_W'(gait_prob));

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			prod_h_s1 <= PROD_W'($signed({1'b0, cfg.force_noise})) * PROD_W'(dh);
			prod_f_s1 <= PROD_W'($signed({1'b0, cfg.height_noise})) * PROD_W'(df);
			g_s1 <= gait_prob;

			num_s2 <= NUM_W'(prod_h_s1) + NUM_W'(prod_f_s1);
			g_s2 <= g_s1;

			neg_s3 <= num_s2[NUM_W-1];
			mag_s3 <= MAG_W'(num_s2[NUM_W-1] ? -num_s2 : num_s2);
			skip_s3 <= (num_s2 == '0);
			g_s3 <= g_s2;

			// The magnitude is split in halves to keep each product at 32 by 25 bits.
			pp_lo_s4 <= PP_W'(cfg.process_noise) * PP_W'(mag_s3[MAG_LO_W-1:0]);
			pp_hi_s4 <= PP_W'(cfg.process_noise) * PP_W'(mag_s3[MAG_W-1:MAG_LO_W]);
			neg_s4 <= neg_s3;
			skip_s4 <= skip_s3;
			g_s4 <= g_s3;

			top_s5 <= TOP_W'(pp_lo_s4) + (TOP_W'(pp_hi_s4) << MAG_LO_W);
			neg_s5 <= neg_s4;
			skip_s5 <= skip_s4;
			g_s5 <= g_s4;

			// Adding the denominator before dividing by twice it rounds halves upward.
			n_s6 <= (REM_W'(top_s5) << 1) + REM_W'(cfg.den2[D2_W-1:1]);
			neg_s6 <= neg_s5;
			skip_s6 <= skip_s5;
			g_s6 <= g_s5;

			dv_rem_s[0] <= n_s6;
			dv_quo_s[0] <= '0;
			dv_ovf_s[0] <= (n_s6 >= {cfg.den2, {QUO_W{1'b0}}});
			dv_neg_s[0] <= neg_s6;
			dv_skip_s[0] <= skip_s6;
			dv_g_s[0] <= g_s6;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int B = QUO_W - 1 - j;
		logic [REM_W:0] trial;
		logic           fits;

		assign trial = {1'b0, dv_rem_s[j]} - {1'b0, (REM_W'(cfg.den2) << B)};
		assign fits = !trial[REM_W];

		always_ff @(posedge clk) begin
			if (ctl.advance) begin
				dv_rem_s[j+1] <= fits ? trial[REM_W-1:0] : dv_rem_s[j];
				dv_quo_s[j+1] <= {dv_quo_s[j][QUO_W-2:0], fits};
				dv_ovf_s[j+1] <= dv_ovf_s[j];
				dv_neg_s[j+1] <= dv_neg_s[j];
				dv_skip_s[j+1] <= dv_skip_s[j];
				dv_g_s[j+1] <= dv_g_s[j];
			end
		end
	end

	always_comb begin
		if (dv_skip_s[QUO_W] || cfg.den_zero) begin
			delta = '0;
		end else if (dv_ovf_s[QUO_W]) begin
			delta = {1'b1, {QUO_W{1'b0}}};
		end else begin
			delta = DELTA_W'(dv_quo_s[QUO_W]);
		end
		if (dv_neg_s[QUO_W]) begin
			res = $signed(RES_W'(dv_g_s[QUO_W]) - RES_W'(delta));
		end else begin
			res = $signed(RES_W'(dv_g_s[QUO_W]) + RES_W'(delta));
		end
		if (res < 0) begin
			sat = '0;
		end else if (res > $signed(RES_W'(PROB_ONE))) begin
			sat = PROB_ONE;
		end else begin
			sat = res[PROB_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			fused_s25 <= sat;
		end
		if (ctl.skid_load) begin
			skid_q <= fused_s25;
		end
	end

	assign fused_prob = ctl.skid_sel ? skid_q : fused_s25;

endmodule

`default_nettype wire

// ===== rtl/contact_probability_kalman_fusion.sv =====
// Top level of the contact probability fusion block: register port, pipeline control
// and one datapath per leg. Depends on cpkf_pkg, cpkf_cfg, cpkf_ctrl and cpkf_leg.
//
//   channel   direction  handshake             payload
//   config    in/out     psel/penable/pready   paddr, pwdata, pwrite, prdata
//   request   in         in_valid/in_ready     gait_prob_*, height_prob_*, force_prob_*
//   result    out        out_valid/out_ready   fused_prob_*
//
// One request enters per cycle while in_ready is high; its result passes through the
// seven arithmetic stages, the 17 divider steps and the output stage.
// After reset and after every register write, in_ready stays low while the shared
// denominator is rebuilt from the noise registers.
// A held result moves into a one-entry skid stage, so one more request is taken;
// the pipeline then freezes until the result is taken, and nothing is lost.
`default_nettype none

module contact_probability_kalman_fusion (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cpkf_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [cpkf_pkg::REG_W-1:0]   pwdata,
	output logic [cpkf_pkg::REG_W-1:0]        prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  gait_prob_0,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  gait_prob_1,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  gait_prob_2,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  gait_prob_3,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  height_prob_0,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  height_prob_1,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  height_prob_2,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  height_prob_3,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  force_prob_0,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  force_prob_1,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  force_prob_2,
	input  wire logic [cpkf_pkg::PROB_W-1:0]  force_prob_3,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [cpkf_pkg::PROB_W-1:0]       fused_prob_0,
	output logic [cpkf_pkg::PROB_W-1:0]       fused_prob_1,
	output logic [cpkf_pkg::PROB_W-1:0]       fused_prob_2,
	output logic [cpkf_pkg::PROB_W-1:0]       fused_prob_3
);
	import cpkf_pkg::*;

	cfg_bus_t          cfg;
	pipe_ctl_t         ctl;
	logic              settled;
	logic [PROB_W-1:0] gait_v   [LEG_COUNT];
	logic [PROB_W-1:0] height_v [LEG_COUNT];
	logic [PROB_W-1:0] force_v  [LEG_COUNT];
	logic [PROB_W-1:0] fused_v  [LEG_COUNT];

	assign gait_v[0] = gait_prob_0;
	assign gait_v[1] = gait_prob_1;
	assign gait_v[2] = gait_prob_2;
	assign gait_v[3] = gait_prob_3;
	assign height_v[0] = height_prob_0;
	assign height_v[1] = height_prob_1;
	assign height_v[2] = height_prob_2;
	assign height_v[3] = height_prob_3;
	assign force_v[0] = force_prob_0;
	assign force_v[1] = force_prob_1;
	assign force_v[2] = force_prob_2;
	assign force_v[3] = force_prob_3;
	assign fused_prob_0 = fused_v[0];
	assign fused_prob_1 = fused_v[1];
	assign fused_prob_2 = fused_v[2];
	assign fused_prob_3 = fused_v[3];

	cpkf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.settled (settled)
	);

	cpkf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.settled   (settled),
		.ctl       (ctl)
	);

	for (genvar leg = 0; leg < LEG_COUNT; leg++) begin : g_leg
		cpkf_leg u_leg (
			.clk         (clk),
			.cfg         (cfg),
			.ctl         (ctl),
			.gait_prob   (gait_v[leg]),
			.height_prob (height_v[leg]),
			.force_prob  (force_v[leg]),
			.fused_prob  (fused_v[leg])
		);
	end

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fused_prob_0 <= PROB_ONE) && (fused_prob_1 <= PROB_ONE) &&
		(fused_prob_2 <= PROB_ONE) && (fused_prob_3 <= PROB_ONE))
		else $error("fused probability above one");

endmodule

`default_nettype wire

// ===== sim/contact_probability_kalman_fusion_tb.sv =====
// Self-checking testbench for contact_probability_kalman_fusion: APB register setup,
// directed and random requests, and a per-leg Kalman correction model for the results.
// Depends on cpkf_pkg and the block's RTL only.
`default_nettype none

module contact_probability_kalman_fusion_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpkf_pkg::*;

	localparam int RESULT_LATENCY = 25;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_LIMIT = 5000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES = 11;
	localparam int PHASE_REQUESTS = 154;
	localparam int DIRECTED_ROWS = 17;

	typedef logic [LEG_COUNT-1:0][PROB_W-1:0] leg_probs_t;

	typedef struct packed {
		leg_probs_t gait;
		leg_probs_t height;
		leg_probs_t foot_force;
	} request_t;

	// One value per input class, applied to every leg.
	typedef struct packed {
		logic [PROB_W-1:0] gait;
		logic [PROB_W-1:0] height;
		logic [PROB_W-1:0] foot_force;
		logic              typed;
		logic [PROB_W-1:0] fused;
	} directed_row_t;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'd0,     16'd0,     16'd0,     1'b1, 16'd0},
		'{16'd32768, 16'd32768, 16'd32768, 1'b1, 16'd32768},
		'{16'd16384, 16'd16384, 16'd16384, 1'b1, 16'd16384},
		'{16'd1,     16'd1,     16'd1,     1'b1, 16'd1},
		'{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 16'd32768},
		'{16'd0,     16'hFFFF,  16'hFFFF,  1'b1, 16'd32768},
		'{16'hFFFF,  16'd0,     16'd0,     1'b0, 16'd0},
		'{16'd32768, 16'd0,     16'd0,     1'b0, 16'd0},
		'{16'd0,     16'd32768, 16'd32768, 1'b0, 16'd0},
		'{16'd0,     16'd32768, 16'd0,     1'b0, 16'd0},
		'{16'd0,     16'd0,     16'd32768, 1'b0, 16'd0},
		'{16'd32768, 16'd32768, 16'd0,     1'b0, 16'd0},
		'{16'd32768, 16'd0,     16'd32768, 1'b0, 16'd0},
		'{16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, 16'd0},
		'{16'h5555,  16'hAAAA,  16'h5555,  1'b0, 16'd0},
		'{16'd100,   16'd101,   16'd99,    1'b0, 16'd0},
		'{16'd20000, 16'd0,     16'd40000, 1'b0, 16'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0] pwdata;
	wire logic [REG_W-1:0] prdata;
	wire logic pready;
	logic in_valid;
	wire logic in_ready;
	request_t req_drv;
	wire logic out_valid;
	logic out_ready;
	wire leg_probs_t fused_bus;

	// Register values as the block should hold them.
	logic [REG_W-1:0] noise_q;
	logic [REG_W-1:0] noise_height;
	logic [REG_W-1:0] noise_force;

	leg_probs_t pending_fused_q [$];
	int error_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int settings_used = 1;
	int cycle_count = 0;
	logic hold_off_req = 1'b0;

	contact_probability_kalman_fusion DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.gait_prob_0(req_drv.gait[0]),
		.gait_prob_1(req_drv.gait[1]),
		.gait_prob_2(req_drv.gait[2]),
		.gait_prob_3(req_drv.gait[3]),
		.height_prob_0(req_drv.height[0]),
		.height_prob_1(req_drv.height[1]),
		.height_prob_2(req_drv.height[2]),
		.height_prob_3(req_drv.height[3]),
		.force_prob_0(req_drv.foot_force[0]),
		.force_prob_1(req_drv.foot_force[1]),
		.force_prob_2(req_drv.foot_force[2]),
		.force_prob_3(req_drv.foot_force[3]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fused_prob_0(fused_bus[0]),
		.fused_prob_1(fused_bus[1]),
		.fused_prob_2(fused_bus[2]),
		.fused_prob_3(fused_bus[3])
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, pending_fused_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// Kalman correction of one leg, computed exactly and rounded half away from zero.
	function automatic logic [PROB_W-1:0] kalman_fused_prob(input logic [PROB_W-1:0] g,
			input logic [PROB_W-1:0] h, input logic [PROB_W-1:0] f);
		longint dh;
		longint df;
		longint num;
		longint res;
		logic [127:0] den;
		logic [127:0] mag;
		logic [127:0] top;
		logic [127:0] quo;
		logic [63:0] delta;
		dh = longint'(h) - longint'(g);
		df = longint'(f) - longint'(g);
		num = longint'(noise_force) * dh + longint'(noise_height) * df;
		res = longint'(g);
		den = 128'(noise_q) * (128'(noise_height) + 128'(noise_force))
			+ 128'(noise_height) * 128'(noise_force);
		if (den != 0 && num != 0) begin
			mag = 128'(num < 0 ? -num : num);
			top = (128'(noise_q) * mag) << 1;
			quo = (top + den) / (den << 1);
			delta = quo[63:0];
			if (delta > (64'd1 << 40))
				delta = 64'd1 << 40;
			res = (num < 0) ? res - longint'(delta) : res + longint'(delta);
		end
		if (res < 0)
			res = 0;
		if (res > longint'(PROB_ONE))
			res = longint'(PROB_ONE);
		return res[PROB_W-1:0];
	endfunction

	function automatic leg_probs_t fused_probs_for(input request_t req);
		leg_probs_t probs;
		for (int leg = 0; leg < LEG_COUNT; leg++)
			probs[leg] = kalman_fused_prob(req.gait[leg], req.height[leg], req.foot_force[leg]);
		return probs;
	endfunction

	// Mostly in range, with clusters near a reference value and some values above one.
	function automatic logic [PROB_W-1:0] random_prob(input logic [PROB_W-1:0] near);
		int v;
		v = 0;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 32768;
			2: v = int'($urandom_range(0, 65535));
			3, 4: begin
				v = int'(near) + int'($urandom_range(0, 512)) - 256;
				if (v < 0)
					v = 0;
				if (v > 65535)
					v = 65535;
			end
			default: v = int'($urandom_range(0, 32768));
		endcase
		return v[PROB_W-1:0];
	endfunction

	function automatic request_t random_request();
		request_t req;
		for (int leg = 0; leg < LEG_COUNT; leg++) begin
			req.gait[leg] = random_prob(16'($urandom_range(0, 32768)));
			req.height[leg] = random_prob(req.gait[leg]);
			req.foot_force[leg] = random_prob(req.height[leg]);
		end
		return req;
	endfunction

	function automatic logic [REG_W-1:0] random_noise();
		logic [REG_W-1:0] v;
		v = $urandom >> $urandom_range(0, 31);
		return (v == '0) ? 32'd1 : v;
	endfunction

	task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [REG_W-1:0] wdata,
			output logic [REG_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [REG_W-1:0] want);
		logic [REG_W-1:0] got;
		apb_xfer(1'b0, idx, '0, got);
		if (got !== want) begin
			$display("%0t: register %s read back: expected %0d, actual %0d", $time,
				idx.name(), want, got);
			error_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_noise_reg(input reg_idx_t idx, input logic [REG_W-1:0] value);
		logic [REG_W-1:0] unused;
		apb_xfer(1'b1, idx, value, unused);
		case (idx)
			REG_PROCESS_NOISE: noise_q = value;
			REG_HEIGHT_NOISE: noise_height = value;
			REG_FORCE_NOISE: noise_force = value;
			default: ;
		endcase
		check_reg(idx, value);
	endtask

	// Offers one request and records its expected result once it is accepted.
	task automatic send_request(input request_t req, input logic typed, input leg_probs_t typed_fused);
		@(negedge clk);
		req_drv <= req;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_fused_q.push_back(typed ? typed_fused : fused_probs_for(req));
		requests_sent++;
	endtask

	task automatic pause_requests(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_fused_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_fused_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_fused_q.size());
			error_count++;
			pending_fused_q.delete();
		end
	endtask

	always @(posedge clk) begin : result_check
		leg_probs_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_fused_q.size() == 0) begin
				$display("%0t: result with no request outstanding: actual %h", $time, fused_bus);
				error_count++;
			end else begin
				want = pending_fused_q.pop_front();
				results_checked++;
				for (int leg = 0; leg < LEG_COUNT; leg++) begin
					if (fused_bus[leg] !== want[leg]) begin
						$display("%0t: fused_prob_%0d: expected %0d, actual %0d", $time, leg,
							want[leg], fused_bus[leg]);
						error_count++;
					end
				end
			end
		end
	end

	// The receiver changes its stall pattern every segment; a hold-off request makes it
	// refuse results for a long stretch while requests keep coming.
	initial begin : result_sink
		int seg_len;
		int mode;
		int tick;
		tick = 0;
		forever begin
			seg_len = $urandom_range(8, 160);
			mode = $urandom_range(0, 3);
			repeat (seg_len) begin
				@(negedge clk);
				tick++;
				if (hold_off_req) begin
					out_ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_off_req = 1'b0;
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= (tick % 4 == 0);
						default: out_ready <= ($urandom_range(0, 9) != 0);
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		request_t req;
		leg_probs_t typed_fused;
		logic [REG_W-1:0] q_set;
		logic [REG_W-1:0] r1_set;
		logic [REG_W-1:0] r2_set;
		int burst_left;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_drv = '0;
		out_ready = 1'b0;
		noise_q = PROCESS_NOISE_RST;
		noise_height = HEIGHT_NOISE_RST;
		noise_force = FORCE_NOISE_RST;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_reg(REG_PROCESS_NOISE, PROCESS_NOISE_RST);
		check_reg(REG_HEIGHT_NOISE, HEIGHT_NOISE_RST);
		check_reg(REG_FORCE_NOISE, FORCE_NOISE_RST);

		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			for (int leg = 0; leg < LEG_COUNT; leg++) begin
				req.gait[leg] = directed_rows[row].gait;
				req.height[leg] = directed_rows[row].height;
				req.foot_force[leg] = directed_rows[row].foot_force;
				typed_fused[leg] = directed_rows[row].fused;
			end
			send_request(req, directed_rows[row].typed, typed_fused);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_results();
			q_set = random_noise();
			r1_set = random_noise();
			r2_set = random_noise();
			case (phase)
				0: begin
					q_set = PROCESS_NOISE_RST;
					r1_set = HEIGHT_NOISE_RST;
					r2_set = FORCE_NOISE_RST;
				end
				1: begin
					q_set = '1;
					r1_set = '1;
					r2_set = '1;
				end
				2: begin
					q_set = 32'd1;
					r1_set = 32'd1;
					r2_set = 32'd1;
				end
				// No process noise: the prior passes through, only clamped to the range zero to one.
				3: q_set = '0;
				// Both measurement noises zero make the denominator vanish.
				4: begin
					r1_set = '0;
					r2_set = '0;
				end
				5: begin
					q_set = '1;
					r1_set = 32'd1;
					r2_set = '1;
				end
				6: begin
					q_set = 32'd1;
					r1_set = '1;
					r2_set = 32'd1;
				end
				default: ;
			endcase
			write_noise_reg(REG_PROCESS_NOISE, q_set);
			write_noise_reg(REG_HEIGHT_NOISE, r1_set);
			write_noise_reg(REG_FORCE_NOISE, r2_set);
			settings_used++;
			if (phase == 0)
				hold_off_req = 1'b1;
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (burst_left == 0) begin
					pause_requests($urandom_range(1, 8));
					burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
				end
				send_request(random_request(), 1'b0, '0);
				burst_left--;
			end
		end

		drain_results();
		repeat (RESULT_LATENCY + 10) @(posedge clk);
		$display("Sent %0d requests and checked %0d results under %0d register settings.",
			requests_sent, results_checked, settings_used);
		$display("Settings spanned full-scale and unit noise, zero process noise, a zero "
			, "denominator, and a long receiver hold-off.");
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/cpkf_pkg.sv
rtl/cpkf_cfg.sv
rtl/cpkf_ctrl.sv
rtl/cpkf_leg.sv
rtl/contact_probability_kalman_fusion.sv
sim/contact_probability_kalman_fusion_tb.sv
